// File: rtl/chunk_request_window_control_unit_defines.svh
// Shared assertion macros for the chunk request window control unit.
`ifndef CHUNK_REQUEST_WINDOW_CONTROL_UNIT_DEFINES_SVH
`define CHUNK_REQUEST_WINDOW_CONTROL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CRWC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CRWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/crwc_pkg.sv
`timescale 1ns / 1ps
package crwc_pkg;

  // opcodes of an input word
  localparam logic [1:0] OP_REQ  = 2'd0;
  localparam logic [1:0] OP_SENT = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_DROP    = 2'd2;

  // register indexes
  localparam logic [1:0] REG_INIT_WIN = 2'd0;
  localparam logic [1:0] REG_WIN_CAP  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam int KEY_W  = 20;
  localparam int WIN_W  = 7;
  localparam int TIME_W = 32;
  localparam int POS_W  = 64;
  localparam int LEN_W  = 16;
  localparam int TO_W   = 16;

  localparam logic [6:0] MAX_RESULTS = 7'd64;
  localparam logic [6:0] WIN_MAX     = 7'd64;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic             failed;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } result_t;

  typedef struct packed {
    logic [WIN_W-1:0] init_win;
    logic [WIN_W-1:0] win_cap;
    logic [TO_W-1:0]  timeout;
  } cfg_t;

  // zero acts as one, above 64 acts as 64
  function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (w == '0) r = 7'd1;
    else if (w > WIN_MAX) r = WIN_MAX;
    return r;
  endfunction

endpackage

// File: rtl/crwc_ram.sv
`timescale 1ns / 1ps
module crwc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/crwc_front.sv
`timescale 1ns / 1ps
module crwc_front
  import crwc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // friend[11:0], file[19:12], position[83:20],
                                 // length[99:84], send_failed[100], zero pad
  input  logic [1:0]   s_tuser,  // opcode
  output item_t        item,
  output logic         item_valid,
  input  logic         item_ready
);

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       take;
  logic       push;
  logic       pop;
  item_t      in_word;

  // decode the incoming word; key is friend over file
  always_comb begin
    in_word.opcode = s_tuser;
    in_word.key    = {s_tdata[11:0], s_tdata[19:12]};
    in_word.pos    = s_tdata[83:20];
    in_word.len    = s_tdata[99:84];
    in_word.failed = s_tdata[100];
  end

  assign s_tready   = (cnt != 2'd2);
  assign take       = s_tvalid && s_tready;
  // unknown opcode is taken and discarded here
  assign push       = take && (s_tuser != OP_NONE);
  assign item_valid = (cnt != 2'd0);
  assign item       = fifo[rd_ptr];
  assign pop        = item_valid && item_ready;

  // two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= in_word;
  end

endmodule

// File: rtl/crwc_back.sv
`timescale 1ns / 1ps
`include "chunk_request_window_control_unit_defines.svh"
module crwc_back
  import crwc_pkg::*;
#(
  parameter int FILE_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_ready,
  output result_t res,
  output logic    res_last,
  output logic    res_valid,
  input  logic    res_ready
);

  localparam int SW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = $clog2(FILE_SLOTS * QUEUE_DEPTH);
  localparam int DW  = POS_W + LEN_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_ERR      = 4'd2;
  localparam logic [3:0] ST_RESOLVE  = 4'd3;
  localparam logic [3:0] ST_REL_CHK  = 4'd4;
  localparam logic [3:0] ST_REL_EMIT = 4'd5;
  localparam logic [3:0] ST_TICK     = 4'd6;
  localparam logic [3:0] ST_FLUSH    = 4'd7;

  logic [3:0]        state;
  item_t             cur;
  logic              tick_mode;
  logic [SW-1:0]     scan_idx;
  logic [SW-1:0]     slot;
  logic              found;
  logic              free_found;
  logic [SW-1:0]     free_slot;
  logic [6:0]        res_cnt;
  logic [TIME_W-1:0] now;

  // per-slot table
  logic              ent_valid [FILE_SLOTS];
  logic [KEY_W-1:0]  ent_key   [FILE_SLOTS];
  logic [WIN_W-1:0]  ent_inf   [FILE_SLOTS];
  logic [WIN_W-1:0]  ent_win   [FILE_SLOTS];
  logic [TIME_W-1:0] ent_touch [FILE_SLOTS];
  logic [QIW-1:0]    q_head    [FILE_SLOTS];
  logic [QCW-1:0]    q_cnt     [FILE_SLOTS];

  // output stage: one held-back result so last can be set once the item ends
  result_t pend;
  logic    pend_valid;
  logic    out_free;
  logic    can_emit;
  logic    emit_en;
  result_t emit_res;
  logic    flush_en;

  // queue memory
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // resolve-time view of the target slot
  logic [SW-1:0]    rs;
  logic [QCW-1:0]   eff_cnt;
  logic [QIW-1:0]   eff_head;
  logic [QIW:0]     tsum;
  logic [QIW-1:0]   tail;
  logic             q_full;
  logic             no_slot;
  logic             rel_go;
  logic             last_slot;
  logic [TIME_W-1:0] age;
  logic [WIN_W-1:0] cap;

  assign out_free  = !res_valid || res_ready;
  assign can_emit  = !pend_valid || out_free;
  assign rs        = found ? slot : free_slot;
  assign eff_cnt   = found ? q_cnt[rs] : '0;
  assign eff_head  = found ? q_head[rs] : '0;
  assign tsum      = (QIW+1)'(eff_head) + (QIW+1)'(eff_cnt);
  assign tail      = (tsum >= (QIW+1)'(QUEUE_DEPTH)) ? QIW'(tsum - (QIW+1)'(QUEUE_DEPTH))
                                                     : QIW'(tsum);
  assign q_full    = (eff_cnt == QCW'(QUEUE_DEPTH));
  assign no_slot   = !found && !free_found;
  assign rel_go    = (res_cnt < MAX_RESULTS) && (ent_inf[slot] < ent_win[slot]) &&
                     (q_cnt[slot] != '0);
  assign last_slot = (slot == SW'(FILE_SLOTS - 1));
  assign age       = now - ent_touch[slot];
  assign cap       = clamp_window(cfg.win_cap);
  assign ram_waddr = AW'(rs * QUEUE_DEPTH + tail);
  assign ram_raddr = AW'(slot * QUEUE_DEPTH + q_head[slot]);

  crwc_ram #(.WIDTH(DW), .DEPTH(FILE_SLOTS * QUEUE_DEPTH)) u_qram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cur.pos, cur.len}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-state result and memory strobes
  always_comb begin
    emit_en    = 1'b0;
    emit_res   = '0;
    flush_en   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_ERR: begin
        emit_en       = can_emit;
        emit_res.kind = KIND_ERROR;
        emit_res.key  = cur.key;
      end
      ST_RESOLVE: begin
        if (can_emit) begin
          if (no_slot || (cur.opcode == OP_REQ && q_full)) begin
            emit_en       = 1'b1;
            emit_res.kind = KIND_DROP;
            emit_res.key  = cur.key;
            if (cur.opcode == OP_REQ) begin
              emit_res.pos = cur.pos;
              emit_res.len = cur.len;
            end
          end else if (cur.opcode == OP_REQ) begin
            ram_we = 1'b1;
          end
        end
      end
      ST_REL_CHK: ram_re = rel_go;
      ST_REL_EMIT: begin
        emit_en       = can_emit;
        emit_res.kind = KIND_RELEASE;
        emit_res.key  = ent_key[slot];
        emit_res.pos  = ram_rdata[DW-1:LEN_W];
        emit_res.len  = ram_rdata[LEN_W-1:0];
      end
      ST_FLUSH: flush_en = pend_valid && out_free;
      default: ;
    endcase
  end

  // sequencer and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      now     <= '0;
      res_cnt <= '0;
      for (int i = 0; i < FILE_SLOTS; i++) ent_valid[i] <= 1'b0;
    end else begin
      if (emit_en) res_cnt <= res_cnt + 7'd1;
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur        <= item;
            res_cnt    <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            scan_idx   <= '0;
            slot       <= '0;
            if (item.opcode == OP_TICK) begin
              tick_mode <= 1'b1;
              now       <= now + 32'd1;
              state     <= ST_TICK;
            end else begin
              tick_mode <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ent_valid[scan_idx] && ent_key[scan_idx] == cur.key && !found) begin
            found <= 1'b1;
            slot  <= scan_idx;
          end
          if (!ent_valid[scan_idx] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= scan_idx;
          end
          if (scan_idx == SW'(FILE_SLOTS - 1)) begin
            state <= (cur.opcode == OP_SENT && cur.failed) ? ST_ERR : ST_RESOLVE;
          end else begin
            scan_idx <= scan_idx + SW'(1);
          end
        end
        ST_ERR: if (can_emit) state <= ST_RESOLVE;
        ST_RESOLVE: begin
          if (can_emit) begin
            if (no_slot) begin
              state <= ST_FLUSH;
            end else begin
              slot          <= rs;
              ent_touch[rs] <= now;
              if (!found) begin
                ent_valid[rs] <= 1'b1;
                ent_key[rs]   <= cur.key;
                ent_win[rs]   <= clamp_window(cfg.init_win);
                q_head[rs]    <= '0;
              end
              if (cur.opcode == OP_REQ) begin
                q_cnt[rs]   <= q_full ? eff_cnt : eff_cnt + QCW'(1);
                if (!found) ent_inf[rs] <= '0;
              end else begin
                q_cnt[rs]   <= eff_cnt;
                if (found && ent_inf[rs] != '0) ent_inf[rs] <= ent_inf[rs] - 7'd1;
                else if (!found) ent_inf[rs] <= '0;
              end
              state <= ST_REL_CHK;
            end
          end
        end
        ST_REL_CHK: begin
          if (rel_go) begin
            state <= ST_REL_EMIT;
          end else if (!tick_mode || last_slot) begin
            state <= ST_FLUSH;
          end else begin
            slot  <= slot + SW'(1);
            state <= ST_TICK;
          end
        end
        ST_REL_EMIT: begin
          if (can_emit) begin
            q_head[slot]  <= (q_head[slot] == QIW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : q_head[slot] + QIW'(1);
            q_cnt[slot]   <= q_cnt[slot] - QCW'(1);
            ent_inf[slot] <= ent_inf[slot] + 7'd1;
            state         <= ST_REL_CHK;
          end
        end
        ST_TICK: begin
          if (!ent_valid[slot] || age > TIME_W'(cfg.timeout)) begin
            ent_valid[slot] <= 1'b0;
            if (last_slot) state <= ST_FLUSH;
            else slot <= slot + SW'(1);
          end else begin
            if (ent_inf[slot] == '0 && q_cnt[slot] != '0 && ent_win[slot] < cap)
              ent_win[slot] <= {ent_win[slot][WIN_W-2:0], 1'b0};
            state <= ST_REL_CHK;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register and held-back result: control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (emit_en) begin
        if (pend_valid) res_valid <= 1'b1;
        pend_valid <= 1'b1;
      end else if (flush_en) begin
        res_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // output register and held-back result: payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      if (pend_valid) begin
        res      <= pend;
        res_last <= 1'b0;
      end
      pend <= emit_res;
    end else if (flush_en) begin
      res      <= pend;
      res_last <= 1'b1;
    end
  end

  `CRWC_ASSERT_IMPLY(a_res_limit, 1'b1, res_cnt <= MAX_RESULTS, "result count over limit")
  `CRWC_ASSERT_IMPLY(a_idle_clean, state == ST_IDLE, !pend_valid, "held result left at idle")
  `CRWC_ASSERT_NEXT(a_pop_starts, item_valid && item_ready, state != ST_IDLE, "item not started")
  `CRWC_ASSERT_IMPLY(a_rel_nonempty, state == ST_REL_EMIT, q_cnt[slot] != '0, "release from empty queue")

endmodule

// File: rtl/chunk_request_window_control_unit.sv
`timescale 1ns / 1ps
// Sliding-window flow controller for chunk requests. Words enter on s_* (opcode
// in s_tuser) through a two-word queue and are worked one at a time. A request
// or chunk-sent word is started, looked up across all FILE_SLOTS slots, then
// updates its entry, runs the release check and closes. A failed send adds an
// error result, and each released request adds a queue read and an emit step,
// since the queue memory read is registered. A tick is started, then passes each
// free or evicted slot, updates the window and runs the release check for each
// live slot, releases requests and closes. Stalls on m_tready can hold any of
// these steps. Results leave on m_* (kind in m_tuser), with m_tlast on the final
// result of a word. After reset the block is ready at once. The config registers
// sit on the APB port at 0x0 initial window, 0x4 window cap and 0x8 timeout.
module chunk_request_window_control_unit
  import crwc_pkg::*;
#(
  parameter int FILE_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // friend_number, file_number, position, length,
                                 // send_failed, zero pad
  input  logic [1:0]   s_tuser,  // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // out_friend, out_file, out_position, out_length,
                                 // zero pad
  output logic [1:0]   m_tuser,  // kind
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t res;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_win <= 7'd16;
      cfg.win_cap  <= 7'd64;
      cfg.timeout  <= 16'd60;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_INIT_WIN: cfg.init_win <= pwdata[6:0];
        REG_WIN_CAP:  cfg.win_cap  <= pwdata[6:0];
        REG_TIMEOUT:  cfg.timeout  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_INIT_WIN: prdata = {25'd0, cfg.init_win};
      REG_WIN_CAP:  prdata = {25'd0, cfg.win_cap};
      REG_TIMEOUT:  prdata = {16'd0, cfg.timeout};
      default:      prdata = 32'd0;
    endcase
  end

  crwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  crwc_back #(.FILE_SLOTS(FILE_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res        (res),
    .res_last   (m_tlast),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready)
  );

  // pack result word
  assign m_tuser = res.kind;
  assign m_tdata = {4'd0, res.len, res.pos, res.key[7:0], res.key[19:8]};

endmodule
